[sv/spot_pkg.sv]
// Shared types and codes for the shape pair overlap test.
`default_nettype none

package spot_pkg;

  // Shape kind carried in a_kind / b_kind.
  typedef enum logic {
    KIND_CIRCLE = 1'b0,
    KIND_RECT   = 1'b1
  } kind_t;

  // Pair classification that travels along the pipeline beside the squares.
  typedef struct packed {
    logic rect_pair;  // both shapes are rectangles
    logic rect_hit;   // interval overlap on both axes
  } flags_t;

endpackage

`default_nettype wire

[sv/spot_if.sv]
// Valid/ready channel interfaces for shape pairs and overlap results.
`default_nettype none

interface spot_pair_if #(
  parameter int COORD_WIDTH = 20
) ();
  logic                          valid;
  logic                          ready;
  logic                          a_kind;
  logic signed [COORD_WIDTH-1:0] a_p0;
  logic signed [COORD_WIDTH-1:0] a_p1;
  logic signed [COORD_WIDTH-1:0] a_p2;
  logic signed [COORD_WIDTH-1:0] a_p3;
  logic                          b_kind;
  logic signed [COORD_WIDTH-1:0] b_p0;
  logic signed [COORD_WIDTH-1:0] b_p1;
  logic signed [COORD_WIDTH-1:0] b_p2;
  logic signed [COORD_WIDTH-1:0] b_p3;

  modport source (
    output valid, a_kind, a_p0, a_p1, a_p2, a_p3, b_kind, b_p0, b_p1, b_p2, b_p3,
    input  ready
  );
  modport sink (
    input  valid, a_kind, a_p0, a_p1, a_p2, a_p3, b_kind, b_p0, b_p1, b_p2, b_p3,
    output ready
  );
endinterface

interface spot_result_if ();
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

`default_nettype wire

[sv/spot_prep.sv]
// Operand selection: classify the pair and form the magnitudes to be squared.
`default_nettype none

module spot_prep #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                          a_kind,
  input  wire logic signed [COORD_WIDTH-1:0] a_p [4],
  input  wire logic                          b_kind,
  input  wire logic signed [COORD_WIDTH-1:0] b_p [4],
  output logic             [COORD_WIDTH:0]   term [4],
  output logic             [COORD_WIDTH:0]   rad,
  output spot_pkg::flags_t                   flags
);

  localparam int MW = COORD_WIDTH + 1;

  logic signed [MW-1:0] ax [4];
  logic signed [MW-1:0] bx [4];
  logic signed [MW-1:0] cx [4];  // circle, sign extended
  logic signed [MW-1:0] rx [4];  // rectangle, sign extended
  logic                 a_circ;
  logic                 b_circ;

  // Magnitude of a difference; the most negative value maps to 2^(MW-1) unsigned.
  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
    logic [MW-1:0] r;
    r = v[MW-1] ? MW'(-v) : MW'(v);
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ax[i] = MW'(a_p[i]);
      bx[i] = MW'(b_p[i]);
    end
  end

  assign a_circ = (a_kind == spot_pkg::KIND_CIRCLE);
  assign b_circ = (b_kind == spot_pkg::KIND_CIRCLE);

  // Circle/rectangle roles for the mixed case.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cx[i] = a_circ ? ax[i] : bx[i];
      rx[i] = a_circ ? bx[i] : ax[i];
    end
  end

  always_comb begin
    flags.rect_pair = !a_circ && !b_circ;
    flags.rect_hit  = (ax[0] <= bx[2]) && (ax[2] >= bx[0]) &&
                      (ax[1] <= bx[3]) && (ax[3] >= bx[1]);
    if (a_circ && b_circ) begin
      term[0] = mag(ax[0] - bx[0]);
      term[1] = mag(ax[1] - bx[1]);
      term[2] = '0;
      term[3] = '0;
      rad     = mag(ax[2] + bx[2]);
    end else begin
      // An inverted box can put the centre below min and above max at once.
      term[0] = (cx[0] < rx[0]) ? mag(rx[0] - cx[0]) : '0;
      term[1] = (cx[0] > rx[2]) ? mag(cx[0] - rx[2]) : '0;
      term[2] = (cx[1] < rx[1]) ? mag(rx[1] - cx[1]) : '0;
      term[3] = (cx[1] > rx[3]) ? mag(cx[1] - rx[3]) : '0;
      rad     = mag(cx[2]);
    end
  end

endmodule

`default_nettype wire

[sv/spot_square.sv]
// Unsigned squarer.
`default_nettype none

module spot_square #(
  parameter int WIDTH = 21
) (
  input  wire logic [WIDTH-1:0]   a,
  output logic      [2*WIDTH-1:0] sq
);

  assign sq = (2*WIDTH)'(a) * (2*WIDTH)'(a);

endmodule

`default_nettype wire

[sv/spot_judge.sv]
// Final decision: sum of squared distances against squared radius, or box result.
`default_nettype none

module spot_judge #(
  parameter int SQ_WIDTH = 42
) (
  input  wire logic [SQ_WIDTH-1:0] sq [4],
  input  wire logic [SQ_WIDTH-1:0] rad_sq,
  input  wire spot_pkg::flags_t    flags,
  output logic                     overlap
);

  localparam int SUM_WIDTH = SQ_WIDTH + 2;

  logic [SUM_WIDTH-1:0] sum_sq;

  assign sum_sq = SUM_WIDTH'(sq[0]) + SUM_WIDTH'(sq[1]) +
                  SUM_WIDTH'(sq[2]) + SUM_WIDTH'(sq[3]);

  assign overlap = flags.rect_pair ? flags.rect_hit : (sum_sq <= SUM_WIDTH'(rad_sq));

endmodule

`default_nettype wire

[sv/shape_pair_overlap_test.sv]
// Shape pair overlap test: circle / axis-aligned rectangle touch check, top level.
//
// One shape pair is accepted per cycle while the pair port is ready. The
// pipeline has four registers: the input pair, the selected
// distance magnitudes, the squares (five squarers of COORD_WIDTH+1 bits in
// parallel), and the result. Each stage moves whenever the stage after it is
// empty or moving, so bubbles close up and the pair port stays ready while a
// result waits, until all four stages hold transactions. Reset is synchronous
// and empties the pipeline; there is no other state.
`default_nettype none

module shape_pair_overlap_test #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic     clk,
  input  wire logic     rst,
  spot_pair_if.sink     pair,
  spot_result_if.source result
);

  localparam int MW = COORD_WIDTH + 1;
  localparam int SW = 2 * MW;

  // Stage valids and advance enables.
  logic vld_a, vld_b, vld_c, vld_d;
  logic adv_a, adv_b, adv_c, adv_d;

  // Stage A: input pair.
  logic                          a_kind_a;
  logic                          b_kind_a;
  logic signed [COORD_WIDTH-1:0] ap_a [4];
  logic signed [COORD_WIDTH-1:0] bp_a [4];

  // Stage B: magnitudes.
  logic [MW-1:0]    term_next [4];
  logic [MW-1:0]    rad_next;
  spot_pkg::flags_t flags_next;
  logic [MW-1:0]    term_b [4];
  logic [MW-1:0]    rad_b;
  spot_pkg::flags_t flags_b;

  // Stage C: squares.
  logic [SW-1:0]    sq_next [4];
  logic [SW-1:0]    rsq_next;
  logic [SW-1:0]    sq_c [4];
  logic [SW-1:0]    rsq_c;
  spot_pkg::flags_t flags_c;

  // Stage D: result.
  logic overlap_next;
  logic overlap;

  assign adv_d = !vld_d || result.ready;
  assign adv_c = !vld_c || adv_d;
  assign adv_b = !vld_b || adv_c;
  assign adv_a = !vld_a || adv_b;

  assign pair.ready     = adv_a;
  assign result.valid   = vld_d;
  assign result.overlap = overlap;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else begin
      if (adv_a) vld_a <= pair.valid;
      if (adv_b) vld_b <= vld_a;
      if (adv_c) vld_c <= vld_b;
      if (adv_d) vld_d <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && pair.valid) begin
      a_kind_a <= pair.a_kind;
      b_kind_a <= pair.b_kind;
      ap_a[0]  <= pair.a_p0;
      ap_a[1]  <= pair.a_p1;
      ap_a[2]  <= pair.a_p2;
      ap_a[3]  <= pair.a_p3;
      bp_a[0]  <= pair.b_p0;
      bp_a[1]  <= pair.b_p1;
      bp_a[2]  <= pair.b_p2;
      bp_a[3]  <= pair.b_p3;
    end
  end

  spot_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .a_kind(a_kind_a),
    .a_p   (ap_a),
    .b_kind(b_kind_a),
    .b_p   (bp_a),
    .term  (term_next),
    .rad   (rad_next),
    .flags (flags_next)
  );

  always_ff @(posedge clk) begin
    if (adv_b && vld_a) begin
      term_b  <= term_next;
      rad_b   <= rad_next;
      flags_b <= flags_next;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_sq
    spot_square #(
      .WIDTH(MW)
    ) u_sq (
      .a (term_b[g]),
      .sq(sq_next[g])
    );
  end

  spot_square #(
    .WIDTH(MW)
  ) u_rad_sq (
    .a (rad_b),
    .sq(rsq_next)
  );

  always_ff @(posedge clk) begin
    if (adv_c && vld_b) begin
      sq_c    <= sq_next;
      rsq_c   <= rsq_next;
      flags_c <= flags_b;
    end
  end

  spot_judge #(
    .SQ_WIDTH(SW)
  ) u_judge (
    .sq     (sq_c),
    .rad_sq (rsq_c),
    .flags  (flags_c),
    .overlap(overlap_next)
  );

  always_ff @(posedge clk) begin
    if (adv_d && vld_c) begin
      overlap <= overlap_next;
    end
  end

  // Pair port backs up only when every stage is full and the result is stalled.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !pair.ready |-> (vld_a && vld_b && vld_c && vld_d && !result.ready))
    else $error("pair port stalled with room in the pipeline");

  // An accepted transaction occupies stage A on the next edge.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pair.valid && pair.ready) |=> vld_a)
    else $error("accepted pair lost at stage A");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!vld_a && !vld_b && !vld_c && !vld_d))
    else $error("pipeline not empty after reset");

  // A rectangle pair delivers its interval-overlap flag unchanged.
  a_rect_pass: assert property (@(posedge clk) disable iff (rst)
    (vld_c && adv_d && flags_c.rect_pair) |=> (overlap == $past(flags_c.rect_hit)))
    else $error("rectangle pair result mismatch");

endmodule

`default_nettype wire

[tb/sv/shape_pair_overlap_test_tb.sv]
// Self-checking testbench for the circle / rectangle shape pair overlap test.
`timescale 1ns / 100ps

module shape_pair_overlap_test_tb;

  localparam int CW = 20;
  localparam int MAX_C = (1 << (CW - 1)) - 1;
  localparam int MIN_C = -(1 << (CW - 1));
  localparam int RANDOM_PAIRS = 1900;
  localparam int LONG_HOLD = 300;
  // Worst case is far below this: ~2000 pairs, slow receiver.
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 16;

  typedef logic [127:0] sq_t;

  typedef struct {
    spot_pkg::kind_t kind;
    logic signed [CW-1:0] p0;
    logic signed [CW-1:0] p1;
    logic signed [CW-1:0] p2;
    logic signed [CW-1:0] p3;
  } shape_t;

  typedef struct {
    shape_t a;
    shape_t b;
  } shape_pair_t;

  typedef struct {
    shape_pair_t pair;
    bit          wait_idle;  // hold this pair back until every result is in
  } queued_pair_t;

  typedef struct {
    logic overlap;
    int   seq;
  } overlap_due_t;

  logic clk = 1'b0;
  logic rst;

  spot_pair_if #(.COORD_WIDTH(CW)) pair_ch ();
  spot_result_if result_ch ();

  shape_pair_overlap_test #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch.sink),
    .result (result_ch.source)
  );

  always #4 clk = ~clk;

  queued_pair_t pair_backlog[$];
  overlap_due_t overlap_due[$];
  shape_pair_t  offered_pair;
  bit           pair_fired;
  int           pairs_total;
  int           pairs_in;
  int           results_out;
  int           fail_count;
  int           touch_count;
  int           combo_count[4];
  int           drain_pauses;
  int           longest_hold;
  int           cycles;

  // ---------------------------------------------------------------- predictor

  function automatic sq_t sq_mag(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic sq_t outside_sq(longint c, longint lo, longint hi);
    sq_t acc;
    acc = '0;
    if (c < lo) acc += sq_mag(lo - c);
    if (c > hi) acc += sq_mag(c - hi);
    return acc;
  endfunction

  function automatic logic circles_touch(shape_t a, shape_t b);
    sq_t gap_sq;
    gap_sq = sq_mag(longint'(a.p0) - longint'(b.p0)) + sq_mag(longint'(a.p1) - longint'(b.p1));
    return gap_sq <= sq_mag(longint'(a.p2) + longint'(b.p2));
  endfunction

  function automatic logic box_reaches_circle(shape_t r, shape_t c);
    sq_t gap_sq;
    gap_sq = outside_sq(longint'(c.p0), longint'(r.p0), longint'(r.p2))
           + outside_sq(longint'(c.p1), longint'(r.p1), longint'(r.p3));
    return gap_sq <= sq_mag(longint'(c.p2));
  endfunction

  function automatic logic boxes_touch(shape_t a, shape_t b);
    return (a.p0 <= b.p2) && (a.p2 >= b.p0) && (a.p1 <= b.p3) && (a.p3 >= b.p1);
  endfunction

  function automatic logic shapes_touch(shape_pair_t sp);
    if (sp.a.kind == spot_pkg::KIND_CIRCLE && sp.b.kind == spot_pkg::KIND_CIRCLE)
      return circles_touch(sp.a, sp.b);
    if (sp.a.kind == spot_pkg::KIND_CIRCLE) return box_reaches_circle(sp.b, sp.a);
    if (sp.b.kind == spot_pkg::KIND_CIRCLE) return box_reaches_circle(sp.a, sp.b);
    return boxes_touch(sp.a, sp.b);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic shape_t circle_at(int x, int y, int r);
    shape_t s;
    s.kind = spot_pkg::KIND_CIRCLE;
    s.p0 = CW'(x);
    s.p1 = CW'(y);
    s.p2 = CW'(r);
    s.p3 = CW'($urandom);
    return s;
  endfunction

  function automatic shape_t rect_at(int x0, int y0, int x1, int y1);
    shape_t s;
    s.kind = spot_pkg::KIND_RECT;
    s.p0 = CW'(x0);
    s.p1 = CW'(y0);
    s.p2 = CW'(x1);
    s.p3 = CW'(y1);
    return s;
  endfunction

  function automatic shape_t raw_shape();
    shape_t s;
    s.kind = spot_pkg::kind_t'($urandom_range(0, 1));
    s.p0 = CW'($urandom);
    s.p1 = CW'($urandom);
    s.p2 = CW'($urandom);
    s.p3 = CW'($urandom);
    return s;
  endfunction

  function automatic int near_limit();
    return $urandom_range(0, 1) ? MAX_C - int'($urandom_range(0, 255))
                                : MIN_C + int'($urandom_range(0, 255));
  endfunction

  // Shape scattered around a shared center; sometimes inverted or negative radius.
  function automatic shape_t local_shape(int bx, int by, int span);
    int x, y, w, h;
    x = bx + int'($urandom_range(0, 2 * span)) - span;
    y = by + int'($urandom_range(0, 2 * span)) - span;
    if ($urandom_range(0, 1)) begin
      w = $urandom_range(0, span);
      if ($urandom_range(0, 15) == 0) w = -w;
      return circle_at(x, y, w);
    end
    w = $urandom_range(0, span);
    h = $urandom_range(0, span);
    if ($urandom_range(0, 9) == 0) w = -w;
    if ($urandom_range(0, 9) == 0) h = -h;
    return rect_at(x, y, x + w, y + h);
  endfunction

  function automatic shape_pair_t random_pair();
    shape_pair_t sp;
    shape_t      t;
    int          sel, bx, by, span, k, dx, dy, d, nudge, w, h, ra, x0, y0;
    sel = $urandom_range(0, 99);
    bx = int'($urandom_range(0, 600000)) - 300000;
    by = int'($urandom_range(0, 600000)) - 300000;
    if (sel < 15) begin
      sp.a = raw_shape();
      sp.b = raw_shape();
    end else if (sel < 25) begin
      sp.a = raw_shape();
      sp.b = raw_shape();
      sp.a.p0 = CW'(near_limit());
      sp.a.p1 = CW'(near_limit());
      sp.a.p2 = CW'(near_limit());
      sp.a.p3 = CW'(near_limit());
      sp.b.p0 = CW'(near_limit());
      sp.b.p1 = CW'(near_limit());
      sp.b.p2 = CW'(near_limit());
      sp.b.p3 = CW'(near_limit());
    end else if (sel < 65) begin
      span = 1 << $urandom_range(4, 14);
      sp.a = local_shape(bx, by, span);
      sp.b = local_shape(bx, by, span);
    end else begin
      // exact contact built from Pythagorean triples, nudged by one LSB either way
      k = $urandom_range(1, 2000);
      case ($urandom_range(0, 3))
        0: begin dx = 3 * k; dy = 4 * k; d = 5 * k; end
        1: begin dx = 5 * k; dy = 12 * k; d = 13 * k; end
        2: begin dx = 8 * k; dy = 15 * k; d = 17 * k; end
        default: begin dx = 0; dy = k; d = k; end
      endcase
      if ($urandom_range(0, 1)) begin
        w = dx; dx = dy; dy = w;
      end
      nudge = int'($urandom_range(0, 2)) - 1;
      w = $urandom_range(0, 4096);
      h = $urandom_range(0, 4096);
      case ($urandom_range(0, 2))
        0: begin
          ra = $urandom_range(0, d);
          if ($urandom_range(0, 1)) dx = -dx;
          if ($urandom_range(0, 1)) dy = -dy;
          sp.a = circle_at(bx, by, ra);
          sp.b = circle_at(bx + dx, by + dy, d - ra + nudge);
        end
        1: begin
          sp.a = rect_at(bx, by, bx + w, by + h);
          x0 = $urandom_range(0, 1) ? bx + w + dx : bx - dx;
          y0 = $urandom_range(0, 1) ? by + h + dy : by - dy;
          sp.b = circle_at(x0, y0, d + nudge);
        end
        default: begin
          sp.a = rect_at(bx, by, bx + w, by + h);
          x0 = bx + w + nudge;
          y0 = $urandom_range(0, 1) ? by + h + int'($urandom_range(0, 2)) - 1
                                    : by - int'($urandom_range(0, 4096));
          sp.b = rect_at(x0, y0, x0 + int'($urandom_range(0, 4096)),
                         y0 + int'($urandom_range(0, 4096)));
        end
      endcase
    end
    if ($urandom_range(0, 1)) begin
      t = sp.a;
      sp.a = sp.b;
      sp.b = t;
    end
    return sp;
  endfunction

  task automatic add_pair(shape_t a, shape_t b, bit wait_idle = 1'b0);
    queued_pair_t q;
    q.pair.a = a;
    q.pair.b = b;
    q.wait_idle = wait_idle;
    pair_backlog.insert(pair_backlog.size(), q);
  endtask

  task automatic load_directed();
    shape_t box;
    // circles meeting exactly at one point, then one LSB short
    add_pair(circle_at(0, 0, 512), circle_at(768, 1024, 768));
    add_pair(circle_at(0, 0, 512), circle_at(768, 1024, 767));
    add_pair(circle_at(100, 100, 0), circle_at(100, 100, 0));
    // circle grazing a box corner, both operand orders
    box = rect_at(0, 0, 1024, 1024);
    add_pair(box, circle_at(1792, 2048, 1280));
    add_pair(circle_at(1792, 2048, 1280), box);
    add_pair(box, circle_at(1792, 2048, 1279));
    add_pair(circle_at(1792, 2048, 1279), box);
    add_pair(circle_at(512, 512, 0), box);
    // negative radii
    add_pair(circle_at(0, 0, -512), circle_at(768, 1024, -768));
    add_pair(circle_at(0, 0, -512), circle_at(768, 1024, 100));
    add_pair(box, circle_at(1792, 2048, -1280));
    // inverted box: both axis terms count
    add_pair(rect_at(1000, 1000, 0, 0), circle_at(500, 500, 0));
    add_pair(rect_at(1000, 1000, 0, 0), circle_at(500, 500, 1000));
    add_pair(rect_at(100, 100, 0, 0), rect_at(100, 100, 0, 0));
    // boxes sharing an edge, then one LSB apart
    add_pair(rect_at(0, 0, 100, 100), rect_at(100, 0, 200, 100));
    add_pair(rect_at(0, 0, 100, 100), rect_at(101, 0, 200, 100));
    add_pair(rect_at(0, 0, 100, 100), rect_at(0, 100, 100, 200));
    // coordinate extremes; unused fourth circle field at both ends
    add_pair(circle_at(MAX_C, MAX_C, MAX_C), circle_at(MIN_C, MIN_C, MAX_C));
    add_pair(circle_at(MAX_C, MAX_C, MIN_C), circle_at(MIN_C, MIN_C, MIN_C));
    add_pair(rect_at(MIN_C, MIN_C, MAX_C, MAX_C), rect_at(MIN_C, MIN_C, MAX_C, MAX_C));
    add_pair(rect_at(MIN_C, MIN_C, MAX_C, MAX_C), circle_at(MAX_C, MIN_C, 0));
    add_pair(rect_at(MAX_C, MAX_C, MAX_C, MAX_C), circle_at(MIN_C, MIN_C, MAX_C));
    add_pair(rect_at(MAX_C, MAX_C, MAX_C, MAX_C), circle_at(MIN_C, MIN_C, MIN_C));
    pair_backlog[pair_backlog.size() - 1].pair.b.p3 = CW'(MIN_C);
    pair_backlog[pair_backlog.size() - 2].pair.b.p3 = CW'(MAX_C);
  endtask

  // ---------------------------------------------------------------- pair sender

  int burst_left;
  int gap_left;

  always @(negedge clk) begin : pair_driver
    logic offer;
    queued_pair_t q;
    offer = pair_ch.valid && !pair_fired;
    pair_fired = 1'b0;
    if (rst) begin
      offer = 1'b0;
    end else if (!offer) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pair_backlog.size() > 0 &&
                   !(pair_backlog[0].wait_idle && overlap_due.size() > 0)) begin
        q = pair_backlog[0];
        pair_backlog.delete(0);
        if (q.wait_idle) drain_pauses++;
        offered_pair = q.pair;
        pair_ch.a_kind <= q.pair.a.kind;
        pair_ch.a_p0   <= q.pair.a.p0;
        pair_ch.a_p1   <= q.pair.a.p1;
        pair_ch.a_p2   <= q.pair.a.p2;
        pair_ch.a_p3   <= q.pair.a.p3;
        pair_ch.b_kind <= q.pair.b.kind;
        pair_ch.b_p0   <= q.pair.b.p0;
        pair_ch.b_p1   <= q.pair.b.p1;
        pair_ch.b_p2   <= q.pair.b.p2;
        pair_ch.b_p3   <= q.pair.b.p3;
        offer = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // new burst: sometimes a long stretch with no gaps at all
          burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(100, 250)
                                                 : $urandom_range(0, 30);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
        end
      end
    end
    pair_ch.valid <= offer;
  end

  // ---------------------------------------------------------------- result receiver

  int  hold_left;
  int  pace_mode;
  int  pace_left;
  bit  long_hold_done;

  always @(negedge clk) begin : result_pacer
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!long_hold_done && pairs_in >= 600) begin
        // hold off long enough for the pipe to fill and push back on the sender
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        longest_hold = LONG_HOLD;
      end else begin
        if (pace_left == 0) begin
          pace_mode = $urandom_range(0, 3);
          pace_left = $urandom_range(20, 200);
        end
        pace_left--;
        case (pace_mode)
          0: take = 1'b1;
          1: take = $urandom_range(0, 1);
          2: take = ($urandom_range(0, 3) == 0);
          default: take = (cycles % 7) < 4;
        endcase
      end
    end
    result_ch.ready <= take;
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : overlap_checker
    overlap_due_t due;
    if (!rst) begin
      if (pair_ch.valid && pair_ch.ready) begin
        due.overlap = shapes_touch(offered_pair);
        due.seq = pairs_in;
        overlap_due.insert(overlap_due.size(), due);
        combo_count[{offered_pair.a.kind, offered_pair.b.kind}]++;
        if (due.overlap) touch_count++;
        pairs_in++;
        pair_fired = 1'b1;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (overlap_due.size() == 0) begin
          $display("%0t: result transaction with nothing expected, got overlap=%0b",
                   $time, result_ch.overlap);
          fail_count++;
        end else begin
          due = overlap_due[0];
          overlap_due.delete(0);
          if (result_ch.overlap !== due.overlap) begin
            $display("%0t: pair %0d overlap mismatch: expected %0b, got %0b",
                     $time, due.seq, due.overlap, result_ch.overlap);
            fail_count++;
          end
        end
        results_out++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d of %0d pairs sent, %0d results pending",
               $time, pairs_in, pairs_total, overlap_due.size());
      $display("[shape_pair_overlap_test] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    rst = 1'b1;
    pair_ch.valid = 1'b0;
    pair_ch.a_kind = spot_pkg::KIND_CIRCLE;
    pair_ch.a_p0 = '0;
    pair_ch.a_p1 = '0;
    pair_ch.a_p2 = '0;
    pair_ch.a_p3 = '0;
    pair_ch.b_kind = spot_pkg::KIND_CIRCLE;
    pair_ch.b_p0 = '0;
    pair_ch.b_p1 = '0;
    pair_ch.b_p2 = '0;
    pair_ch.b_p3 = '0;
    result_ch.ready = 1'b0;

    load_directed();
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      queued_pair_t q;
      q.pair = random_pair();
      // pause the sender for a full drain a few times along the way
      q.wait_idle = (i == 0) || (i == 900) || (i == 1500);
      pair_backlog.insert(pair_backlog.size(), q);
    end
    pairs_total = pair_backlog.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (!(pairs_in == pairs_total && overlap_due.size() == 0));
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d pairs: circle/circle %0d, circle/box %0d, box/circle %0d, box/box %0d",
             results_out, combo_count[0], combo_count[1], combo_count[2], combo_count[3]);
    $display("%0d touching; receiver held off %0d cycles once, sender drained %0d times",
             touch_count, longest_hold, drain_pauses);
    if (fail_count == 0) begin
      $display("[shape_pair_overlap_test] OK");
    end else begin
      $display("[shape_pair_overlap_test] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/spot_pkg.sv
sv/spot_if.sv
sv/spot_prep.sv
sv/spot_square.sv
sv/spot_judge.sv
sv/shape_pair_overlap_test.sv
tb/sv/shape_pair_overlap_test_tb.sv
